// ===== src/sensor_hub_report_parser_macros.svh =====
// ----------------------------------------------------------------------------
// sensor hub report parser assertion macros
// shared concurrent assertion forms, clocked on clk, quiet during reset
// ----------------------------------------------------------------------------
`ifndef SENSOR_HUB_REPORT_PARSER_MACROS_SVH
`define SENSOR_HUB_REPORT_PARSER_MACROS_SVH

// same-cycle implication
`define SHRP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/shrp_pkg.sv =====
// ----------------------------------------------------------------------------
// shrp_pkg
// types, codes and constants shared by the sensor hub report parser
// ----------------------------------------------------------------------------
package shrp_pkg;

	localparam int QUEUE_DEPTH  = 4;
	localparam int RECORD_BYTES = 8;

	localparam logic [7:0] ID_ACCEL    = 8'h01;
	localparam logic [7:0] ID_GYRO     = 8'h02;
	localparam logic [7:0] ID_MAG      = 8'h03;
	localparam logic [7:0] ID_ROTATION = 8'h05;
	localparam logic [7:0] ID_STAMP    = 8'hFB;

	localparam logic [6:0]  LEN_HIGH_MASK  = 7'h7F;
	localparam logic [14:0] HEADER_LEN     = 15'd4;
	localparam logic [3:0]  REC_LEN_VEC    = 4'd10;
	localparam logic [3:0]  REC_LEN_QUAT   = 4'd14;
	localparam logic [3:0]  STAMP_LEN      = 4'd5;
	localparam logic [3:0]  REC_DATA_FIRST = 4'd4;
	localparam logic [3:0]  REC_DATA_LAST  = 4'd11;

	localparam logic [3:0] FRAC_ACCEL = 4'd8;
	localparam logic [3:0] FRAC_GYRO  = 4'd9;
	localparam logic [3:0] FRAC_MAG   = 4'd4;
	localparam logic [3:0] FRAC_QUAT  = 4'd14;

	typedef enum logic [1:0] {
		KIND_ACCEL = 2'd0,
		KIND_GYRO  = 2'd1,
		KIND_MAG   = 2'd2,
		KIND_QUAT  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_REC_ID  = 3'd2,
		PH_RECORD  = 3'd3,
		PH_DISCARD = 3'd4,
		PH_STAMP   = 3'd5
	} phase_t;

	typedef enum logic {
		REG_REPORT_CHANNEL = 1'b0,
		REG_PAYLOAD_LIMIT  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] report_channel;
		logic [7:0] payload_limit;
	} shrp_cfg_t;

	typedef struct packed {
		logic       emit;
		kind_t      kind;
		logic       store;
		logic [2:0] slot;
		logic [7:0] data;
	} shrp_evt_t;

	typedef struct packed {
		logic      valid;
		shrp_evt_t evt;
	} shrp_push_t;

	typedef struct packed {
		logic      valid;
		shrp_evt_t evt;
	} shrp_head_t;

	function automatic kind_t kind_of_id(input logic [7:0] id);
		kind_t k;
		case (id)
			ID_ACCEL: k = KIND_ACCEL;
			ID_GYRO:  k = KIND_GYRO;
			ID_MAG:   k = KIND_MAG;
			default:  k = KIND_QUAT;
		endcase
		return k;
	endfunction

	function automatic logic [3:0] frac_of(input logic [1:0] kind);
		logic [3:0] f;
		case (kind)
			KIND_ACCEL: f = FRAC_ACCEL;
			KIND_GYRO:  f = FRAC_GYRO;
			KIND_MAG:   f = FRAC_MAG;
			default:    f = FRAC_QUAT;
		endcase
		return f;
	endfunction

endpackage

// ===== src/shrp_byte_if.sv =====
// ----------------------------------------------------------------------------
// shrp_byte_if
// packet byte channel: one byte per transfer, start flag on header byte 0
// ----------------------------------------------------------------------------
interface shrp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       packet_start;

	modport source (output valid, output data_byte, output packet_start, input ready);
	modport sink   (input valid, input data_byte, input packet_start, output ready);
endinterface

// ===== src/shrp_report_if.sv =====
// ----------------------------------------------------------------------------
// shrp_report_if
// sensor report channel: one decoded record per transfer
// ----------------------------------------------------------------------------
interface shrp_report_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  sensor_kind;
	logic signed [15:0] x_raw;
	logic signed [15:0] y_raw;
	logic signed [15:0] z_raw;
	logic signed [15:0] w_raw;
	logic        [3:0]  frac_bits;

	modport source (output valid, output sensor_kind, output x_raw, output y_raw,
		output z_raw, output w_raw, output frac_bits, input ready);
	modport sink   (input valid, input sensor_kind, input x_raw, input y_raw,
		input z_raw, input w_raw, input frac_bits, output ready);
endinterface

// ===== src/shrp_queue.sv =====
// ----------------------------------------------------------------------------
// shrp_queue
// small event fifo between the byte parser and the record assembler
// ----------------------------------------------------------------------------
module shrp_queue import shrp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  shrp_push_t push,
	output logic       full,
	output shrp_head_t head,
	input  logic       pop
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	shrp_evt_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign do_push  = push.valid & ~full;
	assign do_pop   = pop & (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.evt   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== src/shrp_front.sv =====
// ----------------------------------------------------------------------------
// shrp_front
// byte parser: header decode, record framing, store and emit events
// ----------------------------------------------------------------------------
module shrp_front import shrp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	shrp_byte_if.sink  in_ch,
	input  shrp_cfg_t  cfg,
	input  logic       q_full,
	output shrp_push_t push
);
	phase_t      phase_q, phase_n;
	logic [1:0]  hcnt_q, hcnt_n;
	logic [7:0]  len_lo_q, len_lo_n;
	logic [7:0]  plen_q, plen_n;
	logic [7:0]  chan_q, chan_n;
	logic [7:0]  off_q, off_n;
	kind_t       kind_q, kind_n;
	logic [3:0]  idx_q, idx_n;

	logic        acc;
	logic [7:0]  b;
	logic        live;
	logic [14:0] total;
	logic [14:0] pl_full;
	logic [3:0]  idx_inc;
	logic [3:0]  rlen;
	logic [3:0]  id_len;
	logic [8:0]  rec_end;
	logic        known_id;
	logic        store;
	logic        emit;

	assign in_ch.ready = ~q_full;
	assign acc     = in_ch.valid & in_ch.ready;
	assign b       = in_ch.data_byte;
	assign idx_inc = idx_q + 1'b1;
	assign rlen    = (kind_q == KIND_QUAT) ? REC_LEN_QUAT : REC_LEN_VEC;
	assign id_len  = (b == ID_ROTATION) ? REC_LEN_QUAT : REC_LEN_VEC;
	assign rec_end = {1'b0, off_q} + {5'b0, id_len};
	assign total   = {b[6:0] & LEN_HIGH_MASK, len_lo_q};
	assign pl_full = (total > HEADER_LEN) ? total - HEADER_LEN : '0;
	assign known_id = (b == ID_ACCEL) || (b == ID_GYRO) || (b == ID_MAG)
		|| (b == ID_ROTATION);
	assign live = ((phase_q == PH_REC_ID) || (phase_q == PH_RECORD)
		|| (phase_q == PH_STAMP)) && (off_q < plen_q);

	// next state
	always_comb begin
		phase_n  = phase_q;
		hcnt_n   = hcnt_q;
		len_lo_n = len_lo_q;
		plen_n   = plen_q;
		chan_n   = chan_q;
		off_n    = off_q;
		kind_n   = kind_q;
		idx_n    = idx_q;
		if (acc) begin
			if (in_ch.packet_start) begin
				len_lo_n = b;
				hcnt_n   = 2'd1;
				phase_n  = PH_HEADER;
			end else if (phase_q == PH_HEADER) begin
				case (hcnt_q)
					2'd1: begin
						plen_n = (pl_full > {7'b0, cfg.payload_limit})
							? cfg.payload_limit : pl_full[7:0];
						hcnt_n = 2'd2;
					end
					2'd2: begin
						chan_n = b;
						hcnt_n = 2'd3;
					end
					default: begin
						hcnt_n  = 2'd0;
						off_n   = '0;
						phase_n = ((plen_q == '0) || (chan_q != cfg.report_channel))
							? PH_DISCARD : PH_REC_ID;
					end
				endcase
			end else if (live) begin
				off_n = off_q + 1'b1;
				case (phase_q)
					PH_STAMP: begin
						idx_n = idx_inc;
						if (idx_inc >= STAMP_LEN) begin
							phase_n = PH_REC_ID;
						end
					end
					PH_REC_ID: begin
						if (b == ID_STAMP) begin
							idx_n   = 4'd1;
							phase_n = PH_STAMP;
						end else if (known_id) begin
							if (rec_end > {1'b0, plen_q}) begin
								phase_n = PH_DISCARD;
							end else begin
								kind_n  = kind_of_id(b);
								idx_n   = 4'd1;
								phase_n = PH_RECORD;
							end
						end else begin
							phase_n = PH_DISCARD;
						end
					end
					default: begin
						if (idx_inc >= rlen) begin
							phase_n = PH_REC_ID;
							idx_n   = '0;
						end else begin
							idx_n = idx_inc;
						end
					end
				endcase
			end
		end
	end

	// event to the assembler
	always_comb begin
		store = (idx_q >= REC_DATA_FIRST) && (idx_q <= REC_DATA_LAST);
		emit  = (idx_inc >= rlen);
		push.valid     = acc && !in_ch.packet_start && (phase_q == PH_RECORD) && live
			&& (store || emit);
		push.evt.emit  = emit;
		push.evt.kind  = kind_q;
		push.evt.store = store;
		push.evt.slot  = 3'(idx_q - REC_DATA_FIRST);
		push.evt.data  = b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hcnt_q   <= '0;
			len_lo_q <= '0;
			plen_q   <= '0;
			chan_q   <= '0;
			off_q    <= '0;
			kind_q   <= KIND_ACCEL;
			idx_q    <= '0;
		end else begin
			phase_q  <= phase_n;
			hcnt_q   <= hcnt_n;
			len_lo_q <= len_lo_n;
			plen_q   <= plen_n;
			chan_q   <= chan_n;
			off_q    <= off_n;
			kind_q   <= kind_n;
			idx_q    <= idx_n;
		end
	end
endmodule

// ===== src/shrp_back.sv =====
// ----------------------------------------------------------------------------
// shrp_back
// record assembler: collects record bytes and registers decoded reports
// ----------------------------------------------------------------------------
module shrp_back import shrp_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  shrp_head_t      head,
	output logic            pop,
	shrp_report_if.source   out_ch
);
	logic [7:0]         bytes_q [RECORD_BYTES];
	logic [7:0]         bytes_v [RECORD_BYTES];
	logic               valid_q;
	logic [1:0]         kind_q;
	logic signed [15:0] x_q, y_q, z_q, w_q;
	logic [3:0]         frac_q;
	logic               emit_now;

	assign pop      = head.valid && (!head.evt.emit || !valid_q || out_ch.ready);
	assign emit_now = pop && head.evt.emit;

	// record bytes including the one being written this cycle
	always_comb begin
		bytes_v = bytes_q;
		if (head.evt.store) begin
			bytes_v[head.evt.slot] = head.evt.data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.evt.store) begin
			bytes_q[head.evt.slot] <= head.evt.data;
		end
		if (emit_now) begin
			kind_q <= head.evt.kind;
			x_q    <= {bytes_v[1], bytes_v[0]};
			y_q    <= {bytes_v[3], bytes_v[2]};
			z_q    <= {bytes_v[5], bytes_v[4]};
			w_q    <= (head.evt.kind == KIND_QUAT) ? {bytes_v[7], bytes_v[6]} : '0;
			frac_q <= frac_of(head.evt.kind);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (emit_now) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_ch.valid       = valid_q;
	assign out_ch.sensor_kind = kind_q;
	assign out_ch.x_raw       = x_q;
	assign out_ch.y_raw       = y_q;
	assign out_ch.z_raw       = z_q;
	assign out_ch.w_raw       = w_q;
	assign out_ch.frac_bits   = frac_q;
endmodule

// ===== src/sensor_hub_report_parser.sv =====
// ----------------------------------------------------------------------------
// sensor_hub_report_parser
// parses sensor hub packets byte by byte and reports motion sensor records
// ----------------------------------------------------------------------------
// channel   dir  modport  payload
// in_ch     in   sink     data_byte[7:0], packet_start
// out_ch    out  source   sensor_kind, x/y/z/w_raw, frac_bits
// apb       in   slave    report_channel at 0x0, payload_limit at 0x4
//
// one byte transfer per cycle while the fifo has room; a report passes the event fifo, then the output register
// the event fifo (QUEUE_DEPTH entries) lets the parser run while a report waits
// in_ch.ready drops only when the fifo is full
// arst_n clears parser state, fifo pointers and the output valid flag
// ----------------------------------------------------------------------------
module sensor_hub_report_parser import shrp_pkg::*; #(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	shrp_byte_if.sink     in_ch,
	shrp_report_if.source out_ch,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	shrp_cfg_t  cfg_q;
	shrp_push_t push;
	shrp_head_t head;
	logic       q_full;
	logic       pop;
	logic       wr_en;
	reg_idx_t   reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_channel <= 8'd3;
			cfg_q.payload_limit  <= 8'd64;
		end else if (wr_en) begin
			case (reg_sel)
				REG_REPORT_CHANNEL: cfg_q.report_channel <= pwdata[7:0];
				REG_PAYLOAD_LIMIT:  cfg_q.payload_limit  <= pwdata[7:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_REPORT_CHANNEL: prdata = {24'b0, cfg_q.report_channel};
			REG_PAYLOAD_LIMIT:  prdata = {24'b0, cfg_q.payload_limit};
			default:            prdata = '0;
		endcase
	end

	shrp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push)
	);

	shrp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	shrp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);
endmodule

// ===== src/shrp_checker.sv =====
// ----------------------------------------------------------------------------
// shrp_checker
// port-level checks on the report channel and the configuration port
// ----------------------------------------------------------------------------
`include "sensor_hub_report_parser_macros.svh"

module shrp_checker import shrp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic        [1:0]  sensor_kind,
	input logic signed [15:0] w_raw,
	input logic        [3:0]  frac_bits,
	input logic               pready
);
	`SHRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "report dropped while stalled")
	`SHRP_ASSERT_NOW(a_w_zero, out_valid && (sensor_kind != KIND_QUAT), w_raw == 16'sd0, "w_raw set on a vector report")
	`SHRP_ASSERT_NOW(a_frac_kind, out_valid, frac_bits == frac_of(sensor_kind), "fraction bits do not match kind")
	`SHRP_ASSERT_NOW(a_pready, 1'b1, pready, "pready low")
endmodule

bind sensor_hub_report_parser shrp_checker u_shrp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.sensor_kind (out_ch.sensor_kind),
	.w_raw       (out_ch.w_raw),
	.frac_bits   (out_ch.frac_bits),
	.pready      (pready)
);
